### hdl/pu_pkg.sv
package pu_pkg;

  localparam int RANK_W = 22;
  localparam int ELEM_W = 4;
  localparam int FACT_W = 32;

  // Control from the sequencer to the element mask
  typedef struct packed {
    logic load;     // new item: all elements unused, pointer at element 0
    logic advance;  // step pointer to the next unused element above it
    logic take;     // mark pointed element used, pointer to lowest unused
  } mask_ctrl_t;

  // n! for n = 0..12; codes above 12 are never used
  function automatic logic [FACT_W-1:0] fact_of(input logic [ELEM_W-1:0] n);
    logic [FACT_W-1:0] f;
    case (n)
      4'd0:    f = 32'd1;
      4'd1:    f = 32'd1;
      4'd2:    f = 32'd2;
      4'd3:    f = 32'd6;
      4'd4:    f = 32'd24;
      4'd5:    f = 32'd120;
      4'd6:    f = 32'd720;
      4'd7:    f = 32'd5040;
      4'd8:    f = 32'd40320;
      4'd9:    f = 32'd362880;
      4'd10:   f = 32'd3628800;
      4'd11:   f = 32'd39916800;
      4'd12:   f = 32'd479001600;
      default: f = 32'd0;
    endcase
    return f;
  endfunction

endpackage

### hdl/pu_rank_if.sv
interface pu_rank_if;
  logic                      valid;
  logic                      ready;
  logic [pu_pkg::RANK_W-1:0] rank;

  modport source (output valid, output rank, input ready);
  modport sink (input valid, input rank, output ready);
endinterface

### hdl/pu_perm_if.sv
interface pu_perm_if;
  logic                      valid;
  logic                      ready;
  logic [pu_pkg::ELEM_W-1:0] element;
  logic                      last;
  logic                      rank_error;

  modport source (output valid, output element, output last, output rank_error, input ready);
  modport sink (input valid, input element, input last, input rank_error, output ready);
endinterface

### hdl/pu_step.sv
// Shared compare/subtract: remaining rank against the current factorial
module pu_step (
  input  logic [pu_pkg::RANK_W-1:0] rank_left,
  input  logic [pu_pkg::FACT_W-1:0] fact,
  output logic                      ge,
  output logic [pu_pkg::RANK_W-1:0] diff
);

  assign ge   = pu_pkg::FACT_W'(rank_left) >= fact;
  // only used when ge, so fact fits in the rank width
  assign diff = rank_left - fact[pu_pkg::RANK_W-1:0];

endmodule

### hdl/pu_mask.sv
// Unused-element set and a pointer that walks over the unused elements
module pu_mask #(
  parameter int ELEMENT_COUNT = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  pu_pkg::mask_ctrl_t        ctrl,
  output logic [pu_pkg::ELEM_W-1:0] ptr
);

  logic [ELEMENT_COUNT-1:0]  unused_mask;
  logic [ELEMENT_COUNT-1:0]  unused_mask_next;
  logic [pu_pkg::ELEM_W-1:0] ptr_next;
  logic [ELEMENT_COUNT-1:0]  above;
  logic [ELEMENT_COUNT-1:0]  taken;

  function automatic logic [pu_pkg::ELEM_W-1:0] lowest_set(
    input logic [ELEMENT_COUNT-1:0] v
  );
    logic [pu_pkg::ELEM_W-1:0] idx;
    idx = '0;
    for (int i = ELEMENT_COUNT - 1; i >= 0; i--) begin
      if (v[i]) idx = pu_pkg::ELEM_W'(i);
    end
    return idx;
  endfunction

  always_comb begin
    for (int i = 0; i < ELEMENT_COUNT; i++) begin
      above[i] = unused_mask[i] && (pu_pkg::ELEM_W'(i) > ptr);
      taken[i] = unused_mask[i] && (pu_pkg::ELEM_W'(i) != ptr);
    end
  end

  always_comb begin
    unused_mask_next = unused_mask;
    ptr_next         = ptr;
    if (ctrl.load) begin
      unused_mask_next = '1;
      ptr_next         = '0;
    end else if (ctrl.take) begin
      unused_mask_next = taken;
      ptr_next         = lowest_set(taken);
    end else if (ctrl.advance) begin
      ptr_next = lowest_set(above);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unused_mask <= '1;
      ptr         <= '0;
    end else begin
      unused_mask <= unused_mask_next;
      ptr         <= ptr_next;
    end
  end

endmodule

### hdl/permutation_unrank.sv
// Permutation unranking in the factorial number system.
// query: one transfer carries a one-based rank. perm: the block answers with
// ELEMENT_COUNT transfers, the elements of the permutation of 0..N-1 with that
// rank in lexicographic order, first position first; last marks the final one.
// A rank of zero or above N! gives one transfer with rank_error and last set
// and element 0.
// Timing: each position's digit is found by subtracting the factorial of the
// positions left from the remaining rank, one subtraction per cycle in a
// single shared subtractor, while a pointer steps over the unused elements.
// query.ready is high only between items.
// The results leave through an output register; when the receiver stalls the
// sequencer waits at the next result and resumes once it is taken. The next
// rank may be accepted while the final result still waits.
// Reset (rst, synchronous) empties the output register and returns to idle.
module permutation_unrank #(
  parameter int ELEMENT_COUNT = 10
) (
  input  logic       clk,
  input  logic       rst,
  pu_rank_if.sink    query,
  pu_perm_if.source  perm
);

  localparam logic [pu_pkg::ELEM_W-1:0] N_CODE = pu_pkg::ELEM_W'(ELEMENT_COUNT);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_ERR  = 3'b100
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic [pu_pkg::RANK_W-1:0] rank_left;
  logic [pu_pkg::RANK_W-1:0] rank_left_next;
  logic [pu_pkg::ELEM_W-1:0] position;
  logic [pu_pkg::ELEM_W-1:0] position_next;

  logic                      out_valid;
  logic [pu_pkg::ELEM_W-1:0] out_element;
  logic                      out_last;
  logic                      out_error;
  logic                      out_load;
  logic [pu_pkg::ELEM_W-1:0] out_element_next;
  logic                      out_last_next;
  logic                      out_error_next;
  logic                      out_free;

  pu_pkg::mask_ctrl_t        ctrl;
  logic [pu_pkg::ELEM_W-1:0] ptr;
  logic [pu_pkg::FACT_W-1:0] fact;
  logic                      ge;
  logic [pu_pkg::RANK_W-1:0] diff;
  logic                      rank_bad;
  logic                      is_last;

  assign fact     = pu_pkg::fact_of(N_CODE - 4'd1 - position);
  assign rank_bad = (query.rank == '0) ||
                    (pu_pkg::FACT_W'(query.rank) > pu_pkg::fact_of(N_CODE));
  assign is_last  = position == N_CODE - 4'd1;
  assign out_free = !out_valid || perm.ready;

  pu_step u_step (
    .rank_left (rank_left),
    .fact      (fact),
    .ge        (ge),
    .diff      (diff)
  );

  pu_mask #(
    .ELEMENT_COUNT (ELEMENT_COUNT)
  ) u_mask (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .ptr  (ptr)
  );

  assign query.ready = state == ST_IDLE;

  always_comb begin
    state_next       = state;
    rank_left_next   = rank_left;
    position_next    = position;
    ctrl             = '0;
    out_load         = 1'b0;
    out_element_next = out_element;
    out_last_next    = out_last;
    out_error_next   = out_error;
    unique case (state)
      ST_IDLE: begin
        if (query.valid) begin
          if (rank_bad) begin
            state_next = ST_ERR;
          end else begin
            rank_left_next = query.rank - 22'd1;
            position_next  = '0;
            ctrl.load      = 1'b1;
            state_next     = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (ge) begin
          rank_left_next = diff;
          ctrl.advance   = 1'b1;
        end else if (out_free) begin
          out_load         = 1'b1;
          out_element_next = ptr;
          out_last_next    = is_last;
          out_error_next   = 1'b0;
          ctrl.take        = 1'b1;
          position_next    = position + 4'd1;
          if (is_last) state_next = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_element_next = '0;
          out_last_next    = 1'b1;
          out_error_next   = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rank_left <= '0;
      position  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rank_left <= rank_left_next;
      position  <= position_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (perm.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_element <= out_element_next;
      out_last    <= out_last_next;
      out_error   <= out_error_next;
    end
  end

  assign perm.valid      = out_valid;
  assign perm.element    = out_element;
  assign perm.last       = out_last;
  assign perm.rank_error = out_error;

endmodule

### hdl/pu_checker.sv
module pu_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      query_valid,
  input logic                      query_ready,
  input logic                      perm_valid,
  input logic                      perm_ready,
  input logic [pu_pkg::ELEM_W-1:0] perm_element,
  input logic                      perm_last,
  input logic                      perm_rank_error
);

  // an error result stands alone and carries element 0
  assert property (@(posedge clk) disable iff (rst)
    perm_valid && perm_rank_error |-> perm_last && perm_element == '0)
    else $error("rank error result without last or with nonzero element");

  // one item at a time: no new rank right after a transfer in
  assert property (@(posedge clk) disable iff (rst)
    query_valid && query_ready |=> !query_ready)
    else $error("query ready straight after a transfer");

  // a pending middle element means the item is still being worked on
  assert property (@(posedge clk) disable iff (rst)
    perm_valid && !perm_last |-> !query_ready)
    else $error("query ready while a permutation is unfinished");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    perm_valid && !perm_ready |=>
      perm_valid && $stable(perm_element) && $stable(perm_last) &&
      $stable(perm_rank_error))
    else $error("result changed while stalled");

endmodule

bind permutation_unrank pu_checker u_pu_checker (
  .clk             (clk),
  .rst             (rst),
  .query_valid     (query.valid),
  .query_ready     (query.ready),
  .perm_valid      (perm.valid),
  .perm_ready      (perm.ready),
  .perm_element    (perm.element),
  .perm_last       (perm.last),
  .perm_rank_error (perm.rank_error)
);

### tb/unrank_checker.sv
module unrank_checker #(
  parameter int ELEMENT_COUNT = 10
) (
  input  logic clk,
  input  logic rst,
  pu_rank_if   query,
  pu_perm_if   perm,
  output int   error_count,
  output int   outstanding
);

  typedef struct packed {
    logic [pu_pkg::ELEM_W-1:0] element;
    logic                      last;
    logic                      rank_error;
  } perm_word_t;

  perm_word_t perm_expected_q[$];

  function automatic longint unsigned factorial(input int n);
    longint unsigned f;
    int k;
    f = 1;
    for (k = 2; k <= n; k++) f = f * k;
    return f;
  endfunction

  // Walk the factorial digits of rank-1; each digit selects among the elements still free.
  function automatic void predict_permutation(input logic [pu_pkg::RANK_W-1:0] rank_in);
    longint unsigned rem, radix, digit;
    logic [ELEMENT_COUNT-1:0] free_set;
    int pos, e, seen, pick;
    perm_word_t w;
    free_set = '1;
    if (rank_in == 0 || rank_in > factorial(ELEMENT_COUNT)) begin
      w.element = '0;
      w.last = 1'b1;
      w.rank_error = 1'b1;
      perm_expected_q.push_back(w);
      return;
    end
    rem = rank_in - 1;
    for (pos = 0; pos < ELEMENT_COUNT; pos++) begin
      digit = 0;
      if (pos < ELEMENT_COUNT - 1) begin
        radix = factorial(ELEMENT_COUNT - 1 - pos);
        digit = rem / radix;
        rem = rem % radix;
      end
      seen = 0;
      pick = -1;
      for (e = 0; e < ELEMENT_COUNT; e++) begin
        if (free_set[e]) begin
          if (seen == digit && pick < 0) pick = e;
          seen++;
        end
      end
      free_set[pick] = 1'b0;
      w.element = pick[pu_pkg::ELEM_W-1:0];
      w.last = (pos == ELEMENT_COUNT - 1);
      w.rank_error = 1'b0;
      perm_expected_q.push_back(w);
    end
  endfunction

  // Results are registered, so a result never belongs to a rank taken at the same edge.
  always @(posedge clk) begin : watch
    perm_word_t got, want;
    int fails;
    if (rst) begin
      perm_expected_q.delete();
      error_count <= 0;
      outstanding <= 0;
    end else begin
      fails = 0;
      if (perm.valid && perm.ready) begin
        got = '{perm.element, perm.last, perm.rank_error};
        if (perm_expected_q.size() == 0) begin
          $display("%0t: unexpected result element %0d last %0b rank_error %0b",
                   $time, got.element, got.last, got.rank_error);
          fails = 1;
        end else begin
          want = perm_expected_q.pop_front();
          if (got.element !== want.element) begin
            $display("%0t: element expected %0d got %0d", $time, want.element, got.element);
            fails++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
            fails++;
          end
          if (got.rank_error !== want.rank_error) begin
            $display("%0t: rank_error expected %0b got %0b",
                     $time, want.rank_error, got.rank_error);
            fails++;
          end
        end
      end
      if (query.valid && query.ready) predict_permutation(query.rank);
      error_count <= error_count + fails;
      outstanding <= perm_expected_q.size();
    end
  end

endmodule

### tb/tb_top.sv
module tb_top;

  localparam int N = 10;
  localparam int unsigned FULL_RANKS = 3628800;  // 10!
  localparam int RANDOM_ITEMS = 410;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT = 500000;

  typedef enum int {RX_OPEN, RX_BUSY, RX_CHOKED, RX_PERIODIC} rx_mode_t;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   cycle_count = 0;
  int   burst_left = 0;

  logic [pu_pkg::RANK_W-1:0] corner_ranks [0:23] = '{
    0, 1, 2, 3, 6, 7, 24, 120, 121, 720, 5040, 40320,
    362880, 362881, 1814400, 2097152, 3265921, 3628799,
    3628800, 3628801, 4194302, 4194303, 1, 0
  };

  pu_rank_if query_bus();
  pu_perm_if perm_bus();

  permutation_unrank #(.ELEMENT_COUNT(N)) uut (
    .clk   (clk),
    .rst   (rst),
    .query (query_bus),
    .perm  (perm_bus)
  );

  unrank_checker #(.ELEMENT_COUNT(N)) watcher (
    .clk         (clk),
    .rst         (rst),
    .query       (query_bus),
    .perm        (perm_bus),
    .error_count (errors),
    .outstanding (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver back-pressure: modes held for random spans
  initial begin : receiver
    rx_mode_t mode;
    int span, tick;
    perm_bus.ready <= 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(20, 120);
      for (tick = 0; tick < span; tick++) begin
        @(posedge clk);
        case (mode)
          RX_OPEN:  perm_bus.ready <= 1'b1;
          RX_BUSY:  perm_bus.ready <= ($urandom_range(0, 3) != 0);
          RX_CHOKED: perm_bus.ready <= ($urandom_range(0, 3) == 0);
          default:  perm_bus.ready <= ((tick % 12) >= 8);
        endcase
      end
    end
  end

  task automatic send_rank(input logic [pu_pkg::RANK_W-1:0] value);
    query_bus.valid <= 1'b1;
    query_bus.rank <= value;
    do @(posedge clk); while (!query_bus.ready);
  endtask

  task automatic wait_drained;
    query_bus.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Bursts of back-to-back transfers separated by random gaps
  task automatic pace;
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      query_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30) : $urandom_range(0, 6);
    end
  endtask

  function automatic logic [pu_pkg::RANK_W-1:0] random_rank;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 68) return pu_pkg::RANK_W'($urandom_range(1, FULL_RANKS));
    else if (pick < 78) return pu_pkg::RANK_W'($urandom_range(1, 720));
    else if (pick < 86) return pu_pkg::RANK_W'($urandom_range(FULL_RANKS - 50, FULL_RANKS));
    else if (pick < 97) begin
      return pu_pkg::RANK_W'($urandom_range(FULL_RANKS + 1, (1 << pu_pkg::RANK_W) - 1));
    end
    else return '0;
  endfunction

  initial begin : stimulus
    int idx;
    rst <= 1'b1;
    query_bus.valid <= 1'b0;
    query_bus.rank <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (idx = 0; idx < 24; idx++) begin
      send_rank(corner_ranks[idx]);
      if (idx == 3) wait_drained;
    end
    wait_drained;
    for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
      send_rank(random_rank());
      if (idx % 100 == 99) wait_drained;
      else pace();
    end
    wait_drained;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
hdl/pu_pkg.sv
hdl/pu_rank_if.sv
hdl/pu_perm_if.sv
hdl/pu_step.sv
hdl/pu_mask.sv
hdl/permutation_unrank.sv
hdl/pu_checker.sv
tb/unrank_checker.sv
tb/tb_top.sv
